// File: src/sfr_pkg.sv
`default_nettype none

package sfr_pkg;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_START_MARKER = 2'd0;
  localparam logic [1:0] REG_END_MARKER   = 2'd1;
  localparam logic [1:0] REG_MAX_LEN      = 2'd2;

  localparam logic [7:0]  START_MARKER_RST = 8'hAA;
  localparam logic [7:0]  END_MARKER_RST   = 8'h55;
  localparam logic [5:0]  MAX_LEN_RST      = 6'd32;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_DATA   = 3'd1,
    KIND_CRC    = 3'd2,
    KIND_END    = 3'd3,
    KIND_LEN    = 3'd4
  } kind_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  crc_init;
    logic  crc_feed;
    logic  cmd_load;
    logic  len_load;
    logic  crcl_load;
    logic  crch_load;
    logic  data_wr;
    logic  pcnt_inc;
    logic  pcnt_clr;
    logic  good_inc;
    logic  err_inc;
    logic  rd_clr;
    logic  rd_issue;
    logic  rd_adv;
    logic  out_load;
    kind_e out_kind;
    logic  out_last;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic byte_is_start;
    logic byte_is_end;
    logic crc_match;
    logic len_zero;
    logic len_ok;
    logic data_done;
    logic pcnt_zero;
    logic rd_last;
    logic out_free;
  } dp_stat_t;

  // CRC-16/CCITT-FALSE over one byte, MSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/serial_frame_receiver_crc16_unit.sv
`default_nettype none

// Length-prefixed frame receiver with CRC-16/CCITT-FALSE check.
// Input channel: one received byte per transfer (rx_byte_i, in_valid_i/in_ready_o).
// The block hunts for the start marker, then takes command, length, payload,
// CRC low, CRC high and the end marker. Output channel (out_valid_o/out_ready_i)
// carries one result per transfer: a header followed by the payload bytes on a
// good frame, or a single status on a length, CRC or end-marker error.
// A result is registered from the byte that causes it and appears in the cycle
// after that byte. Ordinary bytes are taken at one per cycle except during a
// payload replay: after a good frame with payload, the bytes are read back from
// the payload buffer one at a time (buffer read, then output load), and input
// is held off until the replay ends. A waiting result does not block bytes that
// cannot produce a result; the length and end bytes wait until the output
// register is free or draining. When the receiver stalls, the output holds its
// result and the replay pauses. Reset: hunting for the start marker, counters
// zero, markers 0xAA/0x55, length limit 32, output empty. Configuration is by
// APB writes, made by the user only while idle; the block does not enforce it.

module serial_frame_receiver_crc16_unit #(
  parameter int unsigned BUF_DEPTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sfr_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [sfr_pkg::PDATA_W-1:0]  pwdata,
  output logic      [sfr_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [7:0]                   rx_byte_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [2:0]                   kind_o,
  output logic      [7:0]                   command_o,
  output logic      [7:0]                   frame_len_o,
  output logic      [7:0]                   data_byte_o,
  output logic                              last_o,
  output logic      [31:0]                  good_frames_o,
  output logic      [31:0]                  error_total_o
);

  import sfr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign pready = 1'b1;

  sfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sfr_dp #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .rx_byte_i     (rx_byte_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .command_o     (command_o),
    .frame_len_o   (frame_len_o),
    .data_byte_o   (data_byte_o),
    .last_o        (last_o),
    .good_frames_o (good_frames_o),
    .error_total_o (error_total_o)
  );

endmodule

`default_nettype wire

// File: src/sfr_ram.sv
`default_nettype none

module sfr_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/sfr_ctrl.sv
`default_nettype none

module sfr_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire sfr_pkg::dp_stat_t stat_i,
  output sfr_pkg::dp_cmd_t      cmd_o
);

  import sfr_pkg::*;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_CMD   = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CRCL  = 3'd4,
    PH_CRCH  = 3'd5,
    PH_END   = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_READ,
    ST_PUSH
  } state_e;

  phase_e   phase_q, phase_d;
  state_e   state_q, state_d;
  dp_cmd_t  cmd;
  logic     need_slot;
  logic     in_ready;
  logic     accept;

  // Only the length and end bytes can produce a result right away
  assign need_slot = (phase_q == PH_LEN) || (phase_q == PH_END);
  assign in_ready  = (state_q == ST_RUN) && (!need_slot || stat_i.out_free);
  assign accept    = in_valid_i && in_ready;

  always_comb begin
    cmd     = '0;
    phase_d = phase_q;
    state_d = state_q;
    case (state_q)
      ST_RUN: begin
        if (accept) begin
          case (phase_q)
            PH_CMD: begin
              cmd.cmd_load = 1'b1;
              cmd.crc_feed = 1'b1;
              phase_d      = PH_LEN;
            end
            PH_LEN: begin
              cmd.len_load = 1'b1;
              cmd.crc_feed = 1'b1;
              if (stat_i.len_zero) begin
                phase_d = PH_CRCL;
              end else if (stat_i.len_ok) begin
                phase_d = PH_DATA;
              end else begin
                cmd.err_inc  = 1'b1;
                cmd.out_load = 1'b1;
                cmd.out_kind = KIND_LEN;
                cmd.out_last = 1'b1;
                phase_d      = PH_START;
              end
            end
            PH_DATA: begin
              cmd.data_wr  = 1'b1;
              cmd.crc_feed = 1'b1;
              cmd.pcnt_inc = 1'b1;
              if (stat_i.data_done) begin
                phase_d = PH_CRCL;
              end
            end
            PH_CRCL: begin
              cmd.crcl_load = 1'b1;
              phase_d       = PH_CRCH;
            end
            PH_CRCH: begin
              cmd.crch_load = 1'b1;
              phase_d       = PH_END;
            end
            PH_END: begin
              phase_d      = PH_START;
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
              if (!stat_i.byte_is_end) begin
                cmd.err_inc  = 1'b1;
                cmd.out_kind = KIND_END;
                cmd.pcnt_clr = 1'b1;
              end else if (!stat_i.crc_match) begin
                cmd.err_inc  = 1'b1;
                cmd.out_kind = KIND_CRC;
                cmd.pcnt_clr = 1'b1;
              end else begin
                cmd.good_inc = 1'b1;
                cmd.out_kind = KIND_HEADER;
                if (stat_i.pcnt_zero) begin
                  cmd.pcnt_clr = 1'b1;
                end else begin
                  // payload follows the header: replay it from the buffer
                  cmd.out_last = 1'b0;
                  cmd.rd_clr   = 1'b1;
                  state_d      = ST_READ;
                end
              end
            end
            default: begin
              phase_d = PH_START;
              if (stat_i.byte_is_start) begin
                phase_d      = PH_CMD;
                cmd.pcnt_clr = 1'b1;
                cmd.crc_init = 1'b1;
              end
            end
          endcase
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_d      = ST_PUSH;
      end
      ST_PUSH: begin
        if (stat_i.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_DATA;
          cmd.out_last = stat_i.rd_last;
          cmd.rd_adv   = 1'b1;
          if (stat_i.rd_last) begin
            cmd.pcnt_clr = 1'b1;
            state_d      = ST_RUN;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      state_q <= ST_RUN;
    end else begin
      phase_q <= phase_d;
      state_q <= state_d;
    end
  end

  assign in_ready_o = in_ready;
  assign cmd_o      = cmd;

endmodule

`default_nettype wire

// File: src/sfr_dp.sv
`default_nettype none

module sfr_dp #(
  parameter int unsigned BUF_DEPTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sfr_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [sfr_pkg::PDATA_W-1:0]  pwdata,
  output logic      [sfr_pkg::PDATA_W-1:0]  prdata,
  input  wire logic [7:0]                   rx_byte_i,
  input  wire sfr_pkg::dp_cmd_t             cmd_i,
  output sfr_pkg::dp_stat_t                 stat_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [2:0]                   kind_o,
  output logic      [7:0]                   command_o,
  output logic      [7:0]                   frame_len_o,
  output logic      [7:0]                   data_byte_o,
  output logic                              last_o,
  output logic      [31:0]                  good_frames_o,
  output logic      [31:0]                  error_total_o
);

  import sfr_pkg::*;

  localparam int unsigned AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam logic [5:0] DEPTH_CAP = 6'(BUF_DEPTH);

  // configuration
  logic [7:0]  start_marker_q;
  logic [7:0]  end_marker_q;
  logic [5:0]  max_len_q;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  // frame state
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  len_q, len_d;
  logic [5:0]  pcnt_q, pcnt_d;
  logic [5:0]  pcnt_inc;
  logic [15:0] crc_q, crc_d;
  logic [15:0] crcr_q, crcr_d;
  logic [31:0] good_q, good_d;
  logic [31:0] err_q, err_d;
  logic [5:0]  rd_q, rd_d;
  logic [5:0]  rd_inc;
  logic [5:0]  limit;

  // result register
  logic        out_valid_q;
  logic [2:0]  kind_q;
  logic [7:0]  command_q;
  logic [7:0]  frame_len_q;
  logic [7:0]  data_byte_q;
  logic        last_q;
  logic [31:0] good_frames_q;
  logic [31:0] error_total_q;

  logic        ram_we;
  logic [7:0]  ram_rdata;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= START_MARKER_RST;
      end_marker_q   <= END_MARKER_RST;
      max_len_q      <= MAX_LEN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_START_MARKER: start_marker_q <= pwdata[7:0];
        REG_END_MARKER:   end_marker_q   <= pwdata[7:0];
        REG_MAX_LEN:      max_len_q      <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_START_MARKER: prdata = {24'h0, start_marker_q};
      REG_END_MARKER:   prdata = {24'h0, end_marker_q};
      REG_MAX_LEN:      prdata = {26'h0, max_len_q};
      default:          prdata = '0;
    endcase
  end

  assign limit    = (max_len_q > DEPTH_CAP) ? DEPTH_CAP : max_len_q;
  assign pcnt_inc = pcnt_q + 6'd1;
  assign rd_inc   = rd_q + 6'd1;

  always_comb begin
    cmd_d  = cmd_i.cmd_load  ? rx_byte_i : cmd_q;
    len_d  = cmd_i.len_load  ? rx_byte_i : len_q;
    crc_d  = crc_q;
    crcr_d = crcr_q;
    pcnt_d = pcnt_q;
    rd_d   = rd_q;
    good_d = cmd_i.good_inc ? good_q + 32'd1 : good_q;
    err_d  = cmd_i.err_inc  ? err_q  + 32'd1 : err_q;
    if (cmd_i.crc_init) begin
      crc_d = CRC_INIT;
    end else if (cmd_i.crc_feed) begin
      crc_d = crc_feed(crc_q, rx_byte_i);
    end
    if (cmd_i.crcl_load) begin
      crcr_d = {8'h00, rx_byte_i};
    end else if (cmd_i.crch_load) begin
      crcr_d = {rx_byte_i, crcr_q[7:0]};
    end
    if (cmd_i.pcnt_clr) begin
      pcnt_d = '0;
    end else if (cmd_i.pcnt_inc) begin
      pcnt_d = pcnt_inc;
    end
    if (cmd_i.rd_clr) begin
      rd_d = '0;
    end else if (cmd_i.rd_adv) begin
      rd_d = rd_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q  <= '0;
      len_q  <= '0;
      pcnt_q <= '0;
      crc_q  <= CRC_INIT;
      crcr_q <= '0;
      good_q <= '0;
      err_q  <= '0;
      rd_q   <= '0;
    end else begin
      cmd_q  <= cmd_d;
      len_q  <= len_d;
      pcnt_q <= pcnt_d;
      crc_q  <= crc_d;
      crcr_q <= crcr_d;
      good_q <= good_d;
      err_q  <= err_d;
      rd_q   <= rd_d;
    end
  end

  assign ram_we = cmd_i.data_wr && ({2'b00, pcnt_q} < 8'(BUF_DEPTH));

  sfr_ram #(
    .WIDTH  (8),
    .DEPTH  (BUF_DEPTH),
    .ADDR_W (AW)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pcnt_q[AW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (rd_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Output register: load wins over a same-cycle transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      kind_q        <= cmd_i.out_kind;
      command_q     <= cmd_q;
      frame_len_q   <= len_d;
      data_byte_q   <= (cmd_i.out_kind == KIND_DATA) ? ram_rdata : 8'h00;
      last_q        <= cmd_i.out_last;
      good_frames_q <= good_d;
      error_total_q <= err_d;
    end
  end

  assign stat_o.byte_is_start = (rx_byte_i == start_marker_q);
  assign stat_o.byte_is_end   = (rx_byte_i == end_marker_q);
  assign stat_o.crc_match     = (crc_q == crcr_q);
  assign stat_o.len_zero      = (rx_byte_i == 8'h00);
  assign stat_o.len_ok        = (rx_byte_i <= {2'b00, limit});
  assign stat_o.data_done     = ({2'b00, pcnt_inc} >= len_q);
  assign stat_o.pcnt_zero     = (pcnt_q == 6'd0);
  assign stat_o.rd_last       = (rd_inc == pcnt_q);
  assign stat_o.out_free      = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign command_o     = command_q;
  assign frame_len_o   = frame_len_q;
  assign data_byte_o   = data_byte_q;
  assign last_o        = last_q;
  assign good_frames_o = good_frames_q;
  assign error_total_o = error_total_q;

endmodule

`default_nettype wire

// File: src/sfr_checker.sv
`default_nettype none

module sfr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [2:0]  kind_o,
  input wire logic [7:0]  data_byte_o,
  input wire logic        last_o,
  input wire logic [31:0] good_frames_o
);

  import sfr_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(data_byte_o)
      && $stable(last_o))
    else $error("stalled result changed");

  // status results end their run
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_CRC || kind_o == KIND_END || kind_o == KIND_LEN)
      |-> last_o)
    else $error("error status without last");

  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_DATA |-> data_byte_o == 8'h00)
    else $error("data byte set on non-payload result");

  // good-frame count advances by at most one between back-to-back results
  a_good_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i ##1 out_valid_o
      |-> good_frames_o == $past(good_frames_o)
       || good_frames_o == $past(good_frames_o) + 32'd1)
    else $error("good-frame count jumped");

endmodule

bind serial_frame_receiver_crc16_unit sfr_checker u_sfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .kind_o        (kind_o),
  .data_byte_o   (data_byte_o),
  .last_o        (last_o),
  .good_frames_o (good_frames_o)
);

`default_nettype wire
